FILE: rtl/tgec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgec_pkg
// Shared types and constants for the touch gesture event classifier.
// ----------------------------------------------------------------------------
package tgec_pkg;

    // coordinate width of one raw axis value
    localparam int COORD_BITS = 12;

    // event code that marks a finger in contact
    localparam logic [1:0] EVENT_DOWN = 2'd2;

    // result queue sizing
    localparam int RES_FIFO_DEPTH = 4;
    localparam int RES_PTR_BITS   = $clog2(RES_FIFO_DEPTH);
    localparam int RES_CNT_BITS   = $clog2(RES_FIFO_DEPTH + 1);

    // gesture codes
    typedef enum logic [2:0] {
        KIND_TOUCH_DOWN = 3'd0,
        KIND_TOUCH_DRAG = 3'd1,
        KIND_TOUCH_UP   = 3'd2,
        KIND_PINCH_DOWN = 3'd3,
        KIND_PINCH_DRAG = 3'd4,
        KIND_PINCH_UP   = 3'd5
    } gesture_kind_t;

    // one controller report
    typedef struct packed {
        logic [1:0]            first_event;
        logic [1:0]            second_event;
        logic [COORD_BITS-1:0] first_x;
        logic [COORD_BITS-1:0] first_y;
        logic [COORD_BITS-1:0] second_x;
        logic [COORD_BITS-1:0] second_y;
    } report_t;

    // one gesture result
    typedef struct packed {
        gesture_kind_t         gesture_kind;
        logic [COORD_BITS-1:0] out_first_x;
        logic [COORD_BITS-1:0] out_first_y;
        logic [COORD_BITS-1:0] out_second_x;
        logic [COORD_BITS-1:0] out_second_y;
        logic                  last;
    } gesture_t;

    // one stored contact point
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } point_t;

    // tracking state kept between reports
    typedef struct packed {
        logic   touch_active;
        logic   pinch_active;
        point_t first_pt;
        point_t second_pt;
    } track_state_t;

    // classifier output: up to two results plus the updated state
    typedef struct packed {
        logic [1:0]   res_cnt;
        gesture_t     res0;
        gesture_t     res1;
        track_state_t next_state;
    } class_out_t;

    // result queue status
    typedef struct packed {
        logic [RES_CNT_BITS-1:0] count;
        logic                    room_for_two;
    } fifo_status_t;

endpackage
`default_nettype wire

FILE: rtl/tgec_classify.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgec_classify
// Decodes one report against the tracking state and gives up to two
// gesture results together with the updated state.
// ----------------------------------------------------------------------------
module tgec_classify (
    input  wire tgec_pkg::report_t      report,
    input  wire tgec_pkg::track_state_t cur_state,
    output tgec_pkg::class_out_t        cls
);

    // build a result from a kind and the stored points
    function automatic tgec_pkg::gesture_t make_result(
        input tgec_pkg::gesture_kind_t kind,
        input tgec_pkg::track_state_t  s
    );
        tgec_pkg::gesture_t r;
        r.gesture_kind = kind;
        r.out_first_x  = s.first_pt.x;
        r.out_first_y  = s.first_pt.y;
        r.out_second_x = s.second_pt.x;
        r.out_second_y = s.second_pt.y;
        r.last         = 1'b0;
        return r;
    endfunction

    logic              down1;
    logic              down2;
    tgec_pkg::point_t  pt1;
    tgec_pkg::point_t  pt2;

    // contact decode
    assign down1 = (report.first_event == tgec_pkg::EVENT_DOWN);
    assign down2 = (report.second_event == tgec_pkg::EVENT_DOWN);
    assign pt1   = '{x: report.first_x, y: report.first_y};
    assign pt2   = '{x: report.second_x, y: report.second_y};

    // gesture decision and state update
    always_comb
    begin
        cls.res_cnt    = 2'd0;
        cls.res0       = '0;
        cls.res1       = '0;
        cls.next_state = cur_state;

        if (down1 && down2)
        begin
            if (cur_state.pinch_active)
            begin
                if ((pt1 != cur_state.first_pt) || (pt2 != cur_state.second_pt))
                begin
                    cls.next_state.first_pt  = pt1;
                    cls.next_state.second_pt = pt2;
                    cls.res0    = make_result(tgec_pkg::KIND_PINCH_DRAG, cls.next_state);
                    cls.res_cnt = 2'd1;
                end
            end
            else
            begin
                cls.next_state.pinch_active = 1'b1;
                cls.next_state.first_pt     = pt1;
                cls.next_state.second_pt    = pt2;
                cls.res0    = make_result(tgec_pkg::KIND_PINCH_DOWN, cls.next_state);
                cls.res_cnt = 2'd1;
            end
        end
        else if (down1)
        begin
            if (cur_state.pinch_active)
            begin
                cls.next_state.pinch_active = 1'b0;
                cls.next_state.second_pt    = pt2;
                cls.res0    = make_result(tgec_pkg::KIND_PINCH_UP, cls.next_state);
                cls.res_cnt = 2'd1;
            end
            else if (cur_state.touch_active)
            begin
                if (pt1 != cur_state.first_pt)
                begin
                    cls.next_state.first_pt = pt1;
                    cls.res0    = make_result(tgec_pkg::KIND_TOUCH_DRAG, cls.next_state);
                    cls.res_cnt = 2'd1;
                end
            end
            else
            begin
                cls.next_state.touch_active = 1'b1;
                cls.next_state.first_pt     = pt1;
                cls.res0    = make_result(tgec_pkg::KIND_TOUCH_DOWN, cls.next_state);
                cls.res_cnt = 2'd1;
            end
        end
        else
        begin
            // pinch release comes first, then touch release
            if (cur_state.pinch_active)
            begin
                cls.next_state.pinch_active = 1'b0;
                cls.next_state.second_pt    = pt2;
                cls.res0    = make_result(tgec_pkg::KIND_PINCH_UP, cls.next_state);
                cls.res_cnt = 2'd1;
            end
            if (cur_state.touch_active)
            begin
                cls.next_state.touch_active = 1'b0;
                cls.next_state.first_pt     = pt1;
                if (cur_state.pinch_active)
                begin
                    cls.res1    = make_result(tgec_pkg::KIND_TOUCH_UP, cls.next_state);
                    cls.res_cnt = 2'd2;
                end
                else
                begin
                    cls.res0    = make_result(tgec_pkg::KIND_TOUCH_UP, cls.next_state);
                    cls.res_cnt = 2'd1;
                end
            end
        end

        // mark the final result of the report
        if (cls.res_cnt == 2'd1)
        begin
            cls.res0.last = 1'b1;
        end
        if (cls.res_cnt == 2'd2)
        begin
            cls.res1.last = 1'b1;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/tgec_result_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgec_result_fifo
// Small result queue that takes up to two results per cycle and hands
// out one per request on the output channel.
// ----------------------------------------------------------------------------
module tgec_result_fifo (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire [1:0]                   push_cnt,
    input  wire tgec_pkg::gesture_t     push0,
    input  wire tgec_pkg::gesture_t     push1,
    input  wire                         pop,
    output logic                        not_empty,
    output tgec_pkg::gesture_t          head,
    output tgec_pkg::fifo_status_t      status
);

    localparam int DEPTH  = tgec_pkg::RES_FIFO_DEPTH;
    localparam int PTR_W  = tgec_pkg::RES_PTR_BITS;
    localparam int CNT_W  = tgec_pkg::RES_CNT_BITS;

    tgec_pkg::gesture_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [PTR_W-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = pop ? (rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push1;
        end
    end

    // head of queue and status
    assign not_empty           = (count_reg != '0);
    assign head                = entry_reg[rd_ptr_reg];
    assign status.count        = count_reg;
    assign status.room_for_two = (count_reg <= CNT_W'(DEPTH - 2));

endmodule
`default_nettype wire

FILE: rtl/touch_gesture_event_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_gesture_event_classifier_unit
// Turns touch-controller reports into touch and pinch gesture results.
// ----------------------------------------------------------------------------
// Usage:
//   report channel (report_valid / report_stall / report) takes one
//   controller report per request. gesture channel (gesture_valid /
//   gesture_stall / gesture) gives zero, one or two results per report,
//   the final one of a report flagged by gesture.last.
//   A report is held in an input register until it is taken, classified
//   against the touch/pinch flags and stored points, and its results are
//   written into a four-entry result queue. A report request is first
//   registered in the input register, then its results are registered
//   in the queue, and only then does gesture_valid rise.
//   One report is taken every cycle while the queue has room for two
//   results; a report that gives two results needs two pops at the output, so
//   the output port sets the sustained rate in that case.
//   Reset clears the flags, the stored points and the queue.
//   When the receiver stalls, the queue fills and report_stall rises once
//   fewer than two entries are free; nothing is dropped.
// ----------------------------------------------------------------------------
module touch_gesture_event_classifier_unit (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     report_valid,
    output logic                    report_stall,
    input  wire tgec_pkg::report_t  report,
    output logic                    gesture_valid,
    input  wire                     gesture_stall,
    output tgec_pkg::gesture_t      gesture
);

    logic                     in_valid_reg;
    logic                     in_valid_next;
    tgec_pkg::report_t        in_data_reg;
    tgec_pkg::track_state_t   state_reg;
    tgec_pkg::track_state_t   state_next;
    tgec_pkg::class_out_t     cls;
    tgec_pkg::fifo_status_t   fifo_status;
    logic                     take;
    logic                     accept;
    logic                     pop;
    logic [1:0]               push_cnt;

    // handshake control
    assign take         = in_valid_reg && fifo_status.room_for_two;
    assign report_stall = in_valid_reg && !fifo_status.room_for_two;
    assign accept       = report_valid && !report_stall;
    assign pop          = gesture_valid && !gesture_stall;
    assign push_cnt     = take ? cls.res_cnt : 2'd0;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (take)
        begin
            in_valid_next = 1'b0;
        end
        state_next = take ? cls.next_state : state_reg;
    end

    // input register and tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= report;
        end
    end

    // classification
    tgec_classify u_classify (
        .report    (in_data_reg),
        .cur_state (state_reg),
        .cls       (cls)
    );

    // result queue
    tgec_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (cls.res0),
        .push1     (cls.res1),
        .pop       (pop),
        .not_empty (gesture_valid),
        .head      (gesture),
        .status    (fifo_status)
    );

`ifndef SYNTHESIS
    // queue never overfills
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_status.count <= 3'(tgec_pkg::RES_FIFO_DEPTH))
        else $error("result queue overfilled");

    // a report with results makes the output valid next cycle
    a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (cls.res_cnt != 2'd0)) |=> gesture_valid)
        else $error("result not presented");

    // never more than two results per report
    a_res_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> (cls.res_cnt != 2'd3))
        else $error("illegal result count");

    // a two-result report is always pinch up followed by touch up
    a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && (cls.res_cnt == 2'd2)) |->
        (state_reg.pinch_active && state_reg.touch_active))
        else $error("two results without both gestures active");
`endif

endmodule
`default_nettype wire
